// File: src/uglr_pkg.sv
// Package for the uniform grid linear resampler: payload structs, command and
// status codes, queue and divider types, and sizing constants.
// Has no dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package uglr_pkg;

  // Field widths of the stream payloads.
  localparam int TimeW  = 32;
  localparam int ValueW = 32;
  localparam int StepW  = 32;

  // Grid points emitted per gap before the rest are dropped.
  localparam int MaxPoints = 64;
  localparam int CntW      = 6;

  // Command queue between the front and the back.
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = 1;
  localparam int FifoCntW  = 2;

  // Iterative divider: one quotient bit per cycle.
  localparam int DivSteps = 32;
  localparam int DivCntW  = 5;

  // Configuration port.
  localparam int PAddrW   = 3;
  localparam int PDataW   = 32;
  localparam int RegIdxW  = 1;
  localparam int StepReset = 262;

  typedef enum logic [RegIdxW-1:0] {
    REG_STEP_INTERVAL = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_DROP   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NEW    = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_GAP    = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_EMIT,
    BK_SKIP_GO,
    BK_SKIP_WAIT
  } back_state_e;

  typedef struct packed {
    logic        [TimeW-1:0]  sample_time;
    logic signed [ValueW-1:0] sample_value;
    logic                     new_series;
  } in_item_t;

  typedef struct packed {
    logic        [TimeW-1:0]  grid_time;
    logic signed [ValueW-1:0] grid_value;
    logic        [1:0]        status;
    logic                     last_of_run;
  } out_item_t;

  // One classified sample, as the back needs it.
  typedef struct packed {
    cmd_kind_e                kind;
    logic        [TimeW-1:0]  t0;
    logic        [TimeW-1:0]  t1;
    logic        [ValueW-1:0] v0;
    logic        [TimeW-1:0]  span;
    logic        [ValueW-1:0] mag;
    logic                     neg;
  } cmd_t;

  typedef struct packed {
    logic                        start;
    logic [TimeW+ValueW-1:0]     dividend;
    logic [TimeW-1:0]            divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quotient;
    logic [TimeW-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/uglr_divider.sv
// Restoring divider for the resampler: 64-bit dividend by 32-bit divisor,
// one quotient bit per cycle. Depends on uglr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uglr_divider (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  uglr_pkg::div_req_t  req_i,
  output uglr_pkg::div_rsp_t  rsp_o
);
  import uglr_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [TimeW-1:0]   quo_q, quo_d;
  logic [TimeW-1:0]   dvs_q, dvs_d;

  logic [TimeW:0]     shifted;
  logic [TimeW:0]     trial;
  logic               fits;

  // The caller guarantees that the upper dividend half is below the divisor,
  // so the quotient fits in 32 bits and the remainder in 32 bits.
  assign shifted = {rem_q, quo_q[TimeW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  // One shift-and-subtract step per cycle while busy.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[TimeW+ValueW-1:ValueW];
      quo_d  = req_i.dividend[ValueW-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[TimeW-1:0] : shifted[TimeW-1:0];
      quo_d = {quo_q[TimeW-2:0], fits};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// File: src/uglr_front.sv
// Front of the resampler: accepts samples, keeps the sample history and turns
// each sample into a command for the back. Depends on uglr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uglr_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  uglr_pkg::in_item_t  in_data_i,
  input  wire                 q_full_i,
  output logic                q_push_o,
  output uglr_pkg::cmd_t      q_cmd_o
);
  import uglr_pkg::*;

  logic              have_prev_q, have_prev_d;
  logic [TimeW-1:0]  prev_time_q, prev_time_d;
  logic [ValueW-1:0] prev_value_q, prev_value_d;

  logic              accept;
  logic [ValueW:0]   dv;
  logic [ValueW:0]   dv_neg;
  cmd_kind_e         kind;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the sample against the history.
  always_comb begin
    if (in_data_i.new_series || !have_prev_q) begin
      kind = CMD_NEW;
    end else if (in_data_i.sample_time <= prev_time_q) begin
      kind = CMD_REJECT;
    end else begin
      kind = CMD_GAP;
    end
  end

  // Value difference as a sign and a magnitude; the magnitude fits 32 bits.
  assign dv     = {in_data_i.sample_value[ValueW-1], in_data_i.sample_value}
                - {prev_value_q[ValueW-1], prev_value_q};
  assign dv_neg = -dv;

  always_comb begin
    q_push_o     = accept;
    q_cmd_o.kind = kind;
    q_cmd_o.t0   = prev_time_q;
    q_cmd_o.t1   = in_data_i.sample_time;
    q_cmd_o.v0   = prev_value_q;
    q_cmd_o.span = in_data_i.sample_time - prev_time_q;
    q_cmd_o.neg  = dv[ValueW];
    q_cmd_o.mag  = dv[ValueW] ? dv_neg[ValueW-1:0] : dv[ValueW-1:0];
  end

  // A rejected sample leaves the history alone.
  always_comb begin
    have_prev_d  = have_prev_q;
    prev_time_d  = prev_time_q;
    prev_value_d = prev_value_q;
    if (accept && kind != CMD_REJECT) begin
      have_prev_d  = 1'b1;
      prev_time_d  = in_data_i.sample_time;
      prev_value_d = in_data_i.sample_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_time_q  <= '0;
      prev_value_q <= '0;
    end else begin
      have_prev_q  <= have_prev_d;
      prev_time_q  <= prev_time_d;
      prev_value_q <= prev_value_d;
    end
  end

endmodule

`default_nettype wire

// File: src/uglr_cmd_fifo.sv
// Two-entry command queue between the front and the back of the resampler.
// Depends on uglr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uglr_cmd_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  uglr_pkg::cmd_t   push_data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output uglr_pkg::cmd_t   pop_data_o
);
  import uglr_pkg::*;

  cmd_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o     = count_q == FifoCntW'(FifoDepth);
  assign valid_o    = count_q != '0;
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/uglr_back.sv
// Back of the resampler: walks the grid for each gap command, interpolates each
// point with a multiply and the shared divider, and drives the result
// register. Depends on uglr_pkg and uses uglr_divider through its ports.
`timescale 1ns / 1ps
`default_nettype none

module uglr_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [31:0]           step_i,
  input  wire                  q_valid_i,
  input  uglr_pkg::cmd_t       q_cmd_i,
  output logic                 q_pop_o,
  output uglr_pkg::div_req_t   div_req_o,
  input  uglr_pkg::div_rsp_t   div_rsp_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output uglr_pkg::out_item_t  out_data_o
);
  import uglr_pkg::*;

  back_state_e               state_q, state_d;
  logic        [TimeW:0]     next_q, next_d;
  cmd_t                      cmd_q, cmd_d;
  logic        [CntW-1:0]    cnt_q, cnt_d;
  logic        [63:0]        prod_q, prod_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                      out_free;
  logic        [TimeW-1:0]   dt;
  logic        [TimeW:0]     next_sum;
  logic                      more;
  logic                      at_cap;
  logic        [ValueW-1:0]  value;
  logic        [TimeW:0]     skip_next;

  assign out_free = !out_valid_q || !out_stall_i;

  // Grid arithmetic for the current point.
  assign dt        = next_q[TimeW-1:0] - cmd_q.t0;
  assign next_sum  = next_q + {1'b0, step_i};
  assign more      = next_sum <= {1'b0, cmd_q.t1};
  assign at_cap    = cnt_q == CntW'(MaxPoints - 1);
  assign value     = cmd_q.neg ? cmd_q.v0 - div_rsp_i.quotient
                               : cmd_q.v0 + div_rsp_i.quotient;
  // First grid time past t1: t1 - ((t1 - next) mod step) + step.
  assign skip_next = {1'b0, cmd_q.t1} - {1'b0, div_rsp_i.remainder}
                   + {1'b0, step_i};

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i && q_cmd_i.kind == CMD_GAP
            && next_q <= {1'b0, q_cmd_i.t1}) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:      state_d = BK_DIV_GO;
      BK_DIV_GO:   state_d = BK_DIV_WAIT;
      BK_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          if (!more) begin
            state_d = BK_IDLE;
          end else if (at_cap) begin
            state_d = BK_SKIP_GO;
          end else begin
            state_d = BK_MUL;
          end
        end
      end
      BK_SKIP_GO:  state_d = BK_SKIP_WAIT;
      BK_SKIP_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = BK_IDLE;
        end
      end
      default:     state_d = BK_IDLE;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    q_pop_o            = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = prod_q;
    div_req_o.divisor  = cmd_q.span;
    next_d             = next_q;
    cmd_d              = cmd_q;
    cnt_d              = cnt_q;
    prod_d             = prod_q;
    out_valid_d        = out_valid_q && out_stall_i;
    out_d              = out_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.kind)
            CMD_NEW: begin
              q_pop_o = 1'b1;
              next_d  = {1'b0, q_cmd_i.t1};
            end
            CMD_REJECT: begin
              if (out_free) begin
                q_pop_o           = 1'b1;
                out_valid_d       = 1'b1;
                out_d.grid_time   = '0;
                out_d.grid_value  = '0;
                out_d.status      = ST_REJECT;
                out_d.last_of_run = 1'b1;
              end
            end
            default: begin
              q_pop_o = 1'b1;
              cmd_d   = q_cmd_i;
              cnt_d   = '0;
            end
          endcase
        end
      end
      BK_MUL: begin
        prod_d = 64'(cmd_q.mag) * 64'(dt);
      end
      BK_DIV_GO: begin
        div_req_o.start = 1'b1;
      end
      BK_DIV_WAIT: begin
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.grid_time   = next_q[TimeW-1:0];
          out_d.grid_value  = signed'(value);
          out_d.status      = (more && at_cap) ? ST_DROP : ST_OK;
          out_d.last_of_run = !more || at_cap;
          next_d            = next_sum;
          cnt_d             = cnt_q + CntW'(1);
        end
      end
      BK_SKIP_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = {{ValueW{1'b0}}, cmd_q.t1 - next_q[TimeW-1:0]};
        div_req_o.divisor  = step_i;
      end
      BK_SKIP_WAIT: begin
        if (div_rsp_i.done) begin
          next_d = skip_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      next_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: src/uniform_grid_linear_resampler_top.sv
// Uniform grid linear resampler top: config port, front, queue, back and divider.
// Depends on uglr_pkg and the uglr_* modules. Each grid point takes a multiply and
// a pass through the 32-step divider; a rejected sample's result passes through the
// queue and the back's output register. A gap over its point limit uses the divider
// again to skip the grid ahead.
// Reset clears the history, grid position and queue; the step interval is 262.
`timescale 1ns / 1ps
`default_nettype none

module uniform_grid_linear_resampler_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  uglr_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output uglr_pkg::out_item_t                  out_data_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [uglr_pkg::PAddrW-1:0]          paddr,
  input  wire  [uglr_pkg::PDataW-1:0]          pwdata,
  output logic [uglr_pkg::PDataW-1:0]          prdata,
  output logic                                 pready
);
  import uglr_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] step_eff;
  reg_idx_e         reg_idx;
  logic             cfg_write;

  logic             q_push;
  cmd_t             q_push_cmd;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_pop_cmd;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Configuration register file.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[PAddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    step_d = step_q;
    if (cfg_write && reg_idx == REG_STEP_INTERVAL) begin
      step_d = pwdata;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_INTERVAL: prdata = step_q;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepW'(StepReset);
    end else begin
      step_q <= step_d;
    end
  end

  // A zero step behaves as the smallest step.
  assign step_eff = (step_q == '0) ? StepW'(1) : step_q;

  uglr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_push_cmd)
  );

  uglr_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_pop_cmd)
  );

  uglr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_eff),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_pop_cmd),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  uglr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

`default_nettype wire
